/* sv/bmf_pkg.sv */
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared widths, constants, command/status types and the arctangent table
// for the blob moment feature block.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_CORDIC_STEPS = 16;

  localparam int COORD_W = 10;
  localparam int CNT_W   = 21;
  localparam int SUM_W   = 30;
  localparam int SQ_W    = 40;
  localparam int MOM_W   = 64;
  localparam int PROD_W  = 2 * SUM_W;
  localparam int ORI_W   = 15;
  localparam int DIM_W   = 11;
  localparam int CENT_W  = 18;
  localparam int ASP_W   = 19;
  localparam int ANG_W   = 24;
  localparam int CORD_W  = 34;
  localparam int NORM_W  = 30;

  localparam int DIV_NUM_W = 39;
  localparam int DIV_DEN_W = 21;

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;

  localparam logic signed [ANG_W-1:0] PI_Q20       = 24'sd3294199;
  localparam logic [ORI_W-1:0]        ORIENT_LIMIT = 15'd12868;
  localparam logic [CENT_W-1:0]       CENT_MAX     = 18'd262143;

  // Multiply steps that build the three scaled central moments.
  typedef enum logic [3:0] {
    MUL_A_LO, MUL_A_HI, MUL_A_SQ,
    MUL_B_LO, MUL_B_HI, MUL_B_SQ,
    MUL_C_LO, MUL_C_HI, MUL_C_SQ
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_CX, DIV_CY, DIV_ASP
  } div_sel_e;

  typedef struct packed {
    logic                  pix_take;
    logic                  mul_go;
    mul_sel_e              mul_sel;
    logic                  norm_load;
    logic                  norm_shift;
    logic                  cord_init;
    logic                  cord_step;
    logic [ATAN_IDX_W-1:0] cord_idx;
    logic                  ang_load;
    logic                  div_go;
    div_sel_e              div_sel;
    logic                  out_load;
    logic                  acc_clr;
  } bmf_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic div_done;
  } bmf_status_t;

  // atan(2^-i) in Q20 radians, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    begin
      unique case (idx)
        5'd0:    v = 24'sd823550;
        5'd1:    v = 24'sd486170;
        5'd2:    v = 24'sd256879;
        5'd3:    v = 24'sd130396;
        5'd4:    v = 24'sd65451;
        5'd5:    v = 24'sd32757;
        5'd6:    v = 24'sd16383;
        5'd7:    v = 24'sd8192;
        5'd8:    v = 24'sd4096;
        5'd9:    v = 24'sd2048;
        5'd10:   v = 24'sd1024;
        5'd11:   v = 24'sd512;
        5'd12:   v = 24'sd256;
        5'd13:   v = 24'sd128;
        5'd14:   v = 24'sd64;
        5'd15:   v = 24'sd32;
        5'd16:   v = 24'sd16;
        5'd17:   v = 24'sd8;
        5'd18:   v = 24'sd4;
        5'd19:   v = 24'sd2;
        5'd20:   v = 24'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

/* sv/bmf_div.sv */
// ----------------------------------------------------------------------------
// bmf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmf_div
  import bmf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(DIV_NUM_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 qbit;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = qbit ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* sv/bmf_datapath.sv */
// ----------------------------------------------------------------------------
// bmf_datapath
// Moment accumulators, shared multiplier, normalizer, CORDIC, divider
// operand selection and the result register.
// ----------------------------------------------------------------------------
module bmf_datapath
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bmf_cmd_t                 cmd_i,
  output bmf_status_t              status_o,
  input  logic [COORD_W-1:0]       pix_x_i,
  input  logic [COORD_W-1:0]       pix_y_i,
  output logic [CNT_W-1:0]         area_o,
  output logic [CENT_W-1:0]        centroid_x_o,
  output logic [CENT_W-1:0]        centroid_y_o,
  output logic signed [ORI_W-1:0]  orientation_o,
  output logic [DIM_W-1:0]         box_width_o,
  output logic [DIM_W-1:0]         box_height_o,
  output logic [ASP_W-1:0]         aspect_ratio_o
);

  // Accumulators.
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   sx_q, sy_q;
  logic [SQ_W-1:0]    sxx_q, syy_q, sxy_q;
  logic [COORD_W-1:0] min_c_q, max_c_q, min_r_q, max_r_q;
  logic [COORD_W-1:0] x_cl, y_cl;
  logic [2*COORD_W-1:0] xx, yy, xy;

  always_comb begin
    x_cl = (32'(pix_x_i) > MAX_WIDTH - 1)  ? COORD_W'(MAX_WIDTH - 1)  : pix_x_i;
    y_cl = (32'(pix_y_i) > MAX_HEIGHT - 1) ? COORD_W'(MAX_HEIGHT - 1) : pix_y_i;
    xx   = {{COORD_W{1'b0}}, x_cl} * {{COORD_W{1'b0}}, x_cl};
    yy   = {{COORD_W{1'b0}}, y_cl} * {{COORD_W{1'b0}}, y_cl};
    xy   = {{COORD_W{1'b0}}, x_cl} * {{COORD_W{1'b0}}, y_cl};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      syy_q   <= '0;
      sxy_q   <= '0;
      min_c_q <= '1;
      max_c_q <= '0;
      min_r_q <= '1;
      max_r_q <= '0;
    end else if (cmd_i.acc_clr) begin
      cnt_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      syy_q   <= '0;
      sxy_q   <= '0;
      min_c_q <= '1;
      max_c_q <= '0;
      min_r_q <= '1;
      max_r_q <= '0;
    end else if (cmd_i.pix_take) begin
      cnt_q <= cnt_q + 1'b1;
      sx_q  <= sx_q + SUM_W'(x_cl);
      sy_q  <= sy_q + SUM_W'(y_cl);
      sxx_q <= sxx_q + SQ_W'(xx);
      syy_q <= syy_q + SQ_W'(yy);
      sxy_q <= sxy_q + SQ_W'(xy);
      if (x_cl < min_c_q) min_c_q <= x_cl;
      if (x_cl > max_c_q) max_c_q <= x_cl;
      if (y_cl < min_r_q) min_r_q <= y_cl;
      if (y_cl > max_r_q) max_r_q <= y_cl;
    end
  end

  logic [DIM_W-1:0] box_w, box_h;
  assign box_w = {1'b0, max_c_q} - {1'b0, min_c_q} + DIM_W'(1);
  assign box_h = {1'b0, max_r_q} - {1'b0, min_r_q} + DIM_W'(1);

  // Shared multiplier: n*sxx, n*syy and n*sxy in 20-bit halves, and sum*sum products.
  logic [SUM_W-1:0]  op_a, op_b;
  logic [PROD_W-1:0] prod_q;
  mul_sel_e          psel_q;
  logic              pv_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_A_LO: begin op_a = SUM_W'(cnt_q); op_b = SUM_W'(sxx_q[19:0]); end
      MUL_A_HI: begin op_a = SUM_W'(cnt_q); op_b = SUM_W'(sxx_q[39:20]); end
      MUL_A_SQ: begin op_a = sx_q;          op_b = sx_q; end
      MUL_B_LO: begin op_a = SUM_W'(cnt_q); op_b = SUM_W'(syy_q[19:0]); end
      MUL_B_HI: begin op_a = SUM_W'(cnt_q); op_b = SUM_W'(syy_q[39:20]); end
      MUL_B_SQ: begin op_a = sy_q;          op_b = sy_q; end
      MUL_C_LO: begin op_a = SUM_W'(cnt_q); op_b = SUM_W'(sxy_q[19:0]); end
      MUL_C_HI: begin op_a = SUM_W'(cnt_q); op_b = SUM_W'(sxy_q[39:20]); end
      MUL_C_SQ: begin op_a = sx_q;          op_b = sy_q; end
      default:  begin op_a = '0;            op_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.mul_go;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{SUM_W{1'b0}}, op_a} * {{SUM_W{1'b0}}, op_b};
    psel_q <= cmd_i.mul_sel;
  end

  // Scaled central moments a = n*mu_xx, b = n*mu_yy, c = n*mu_xy.
  logic signed [MOM_W-1:0] a_q, b_q, c_q;
  logic signed [MOM_W-1:0] p_lo, p_hi;

  assign p_lo = MOM_W'(prod_q);
  assign p_hi = {prod_q[MOM_W-21:0], 20'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go && cmd_i.mul_sel == MUL_A_LO) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else if (pv_q) begin
      unique case (psel_q)
        MUL_A_LO: a_q <= a_q + p_lo;
        MUL_A_HI: a_q <= a_q + p_hi;
        MUL_A_SQ: a_q <= a_q - p_lo;
        MUL_B_LO: b_q <= b_q + p_lo;
        MUL_B_HI: b_q <= b_q + p_hi;
        MUL_B_SQ: b_q <= b_q - p_lo;
        MUL_C_LO: c_q <= c_q + p_lo;
        MUL_C_HI: c_q <= c_q + p_hi;
        MUL_C_SQ: c_q <= c_q - p_lo;
        default:  a_q <= a_q;
      endcase
    end
  end

  // Normalizer: magnitudes of 2c and b-a, shifted right together below 2^30.
  logic signed [MOM_W-1:0] ny, dx;
  logic [MOM_W-1:0]        ax_q, ay_q;
  logic                    dx_neg_q, ny_neg_q, zero_q;
  logic                    norm_done, div_done;

  assign ny = {c_q[MOM_W-2:0], 1'b0};
  assign dx = b_q - a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_load) begin
      ax_q     <= dx[MOM_W-1] ? MOM_W'(-dx) : dx;
      ay_q     <= ny[MOM_W-1] ? MOM_W'(-ny) : ny;
      dx_neg_q <= dx[MOM_W-1];
      ny_neg_q <= ny[MOM_W-1];
      zero_q   <= (dx == '0) && (ny == '0);
    end else if (cmd_i.norm_shift) begin
      ax_q <= ax_q >> 1;
      ay_q <= ay_q >> 1;
    end
  end

  assign norm_done = (ax_q[MOM_W-1:NORM_W] == '0) && (ay_q[MOM_W-1:NORM_W] == '0);
  assign status_o  = '{norm_done: norm_done, div_done: div_done};

  // Vectoring CORDIC, one rotation per cycle.
  logic signed [CORD_W-1:0] cx_q, cy_q, cx_sh, cy_sh;
  logic signed [ANG_W-1:0]  z_q, atan_v;

  assign cx_sh  = cx_q >>> cmd_i.cord_idx;
  assign cy_sh  = cy_q >>> cmd_i.cord_idx;
  assign atan_v = atan_q20(cmd_i.cord_idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cord_init) begin
      cx_q <= CORD_W'(ax_q[NORM_W-1:0]);
      cy_q <= CORD_W'(ay_q[NORM_W-1:0]);
      z_q  <= '0;
    end else if (cmd_i.cord_step) begin
      if (!cy_q[CORD_W-1]) begin
        cx_q <= cx_q + cy_sh;
        cy_q <= cy_q - cx_sh;
        z_q  <= z_q + atan_v;
      end else begin
        cx_q <= cx_q - cy_sh;
        cy_q <= cy_q + cx_sh;
        z_q  <= z_q - atan_v;
      end
    end
  end

  // Quadrant fix-up, rounding to Q2.13 and clamping.
  logic signed [ORI_W-1:0] orient_q, orient_d;

  always_comb begin
    logic signed [ANG_W-1:0] full;
    logic [ANG_W-1:0]        mag;
    logic [ANG_W-1:0]        mag_r;
    logic [ORI_W-1:0]        q;
    full = dx_neg_q ? PI_Q20 - z_q : z_q;
    if (ny_neg_q) full = -full;
    if (zero_q) full = '0;
    mag   = full[ANG_W-1] ? ANG_W'(-full) : full;
    mag_r = mag + ANG_W'(128);
    q     = (mag_r[ANG_W-1:8] > 16'(ORIENT_LIMIT)) ? ORIENT_LIMIT : mag_r[ORI_W+7:8];
    orient_d = full[ANG_W-1] ? ORI_W'(-q) : ORI_W'(q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ang_load) orient_q <= orient_d;
  end

  // Divider operands: rounded centroid and aspect ratio.
  logic [DIV_NUM_W-1:0] div_num, quot;
  logic [DIV_DEN_W-1:0] div_den;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_CX: begin
        div_num = {1'b0, sx_q, 8'b0} + DIV_NUM_W'(cnt_q[CNT_W-1:1]);
        div_den = cnt_q;
      end
      DIV_CY: begin
        div_num = {1'b0, sy_q, 8'b0} + DIV_NUM_W'(cnt_q[CNT_W-1:1]);
        div_den = cnt_q;
      end
      DIV_ASP: begin
        div_num = DIV_NUM_W'({box_w, 8'b0}) + DIV_NUM_W'(box_h[DIM_W-1:1]);
        div_den = DIV_DEN_W'(box_h);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  bmf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (quot)
  );

  logic [CENT_W-1:0] cx_res_q, cy_res_q, cent_sat;
  logic [ASP_W-1:0]  asp_q;

  always_comb begin
    if (cnt_q == '0) begin
      cent_sat = '0;
    end else if (quot > DIV_NUM_W'(CENT_MAX)) begin
      cent_sat = CENT_MAX;
    end else begin
      cent_sat = quot[CENT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      unique case (cmd_i.div_sel)
        DIV_CX:  cx_res_q <= cent_sat;
        DIV_CY:  cy_res_q <= cent_sat;
        DIV_ASP: asp_q    <= quot[ASP_W-1:0];
        default: asp_q    <= asp_q;
      endcase
    end
  end

  // Result register.
  logic [CNT_W-1:0]        area_q;
  logic [CENT_W-1:0]       cent_x_q, cent_y_q;
  logic signed [ORI_W-1:0] ori_out_q;
  logic [DIM_W-1:0]        bw_q, bh_q;
  logic [ASP_W-1:0]        asp_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      area_q    <= cnt_q;
      cent_x_q  <= cx_res_q;
      cent_y_q  <= cy_res_q;
      ori_out_q <= orient_q;
      bw_q      <= box_w;
      bh_q      <= box_h;
      asp_out_q <= asp_q;
    end
  end

  assign area_o         = area_q;
  assign centroid_x_o   = cent_x_q;
  assign centroid_y_o   = cent_y_q;
  assign orientation_o  = ori_out_q;
  assign box_width_o    = bw_q;
  assign box_height_o   = bh_q;
  assign aspect_ratio_o = asp_out_q;

endmodule

/* sv/bmf_ctrl.sv */
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: accumulation, moment products, normalize, CORDIC, divisions
// and result hand-off.
// ----------------------------------------------------------------------------
module bmf_ctrl
  import bmf_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        final_pixel_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bmf_cmd_t    cmd_o,
  input  bmf_status_t status_i
);

  localparam logic [3:0] S_ACCUM = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_CORD  = 4'd4;
  localparam logic [3:0] S_ANG   = 4'd5;
  localparam logic [3:0] S_DGO   = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [ATAN_IDX_W-1:0] MUL_LAST = ATAN_IDX_W'(MUL_C_SQ);

  logic [3:0]            state_q, state_d;
  logic [ATAN_IDX_W-1:0] cnt_q, cnt_d;
  div_sel_e              dsel_q, dsel_d;
  logic                  ovalid_q, ovalid_d;
  logic                  out_free;

  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dsel_d  = dsel_q;
    cmd_o   = '0;
    cmd_o.mul_sel  = mul_sel_e'(cnt_q[3:0]);
    cmd_o.cord_idx = cnt_q;
    cmd_o.div_sel  = dsel_q;
    unique case (state_q)
      S_ACCUM: begin
        cmd_o.pix_take = in_valid_i;
        if (in_valid_i && final_pixel_i) begin
          state_d = S_MUL;
          cnt_d   = '0;
        end
      end
      S_MUL: begin
        if (cnt_q > MUL_LAST) begin
          state_d = S_LOAD;
        end else begin
          cmd_o.mul_go = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LOAD: begin
        cmd_o.norm_load = 1'b1;
        state_d = S_NORM;
      end
      S_NORM: begin
        if (status_i.norm_done) begin
          cmd_o.cord_init = 1'b1;
          cnt_d   = '0;
          state_d = S_CORD;
        end else begin
          cmd_o.norm_shift = 1'b1;
        end
      end
      S_CORD: begin
        cmd_o.cord_step = 1'b1;
        if (cnt_q == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
          state_d = S_ANG;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ANG: begin
        cmd_o.ang_load = 1'b1;
        dsel_d  = DIV_CX;
        state_d = S_DGO;
      end
      S_DGO: begin
        cmd_o.div_go = 1'b1;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (status_i.div_done) begin
          if (dsel_q == DIV_ASP) begin
            state_d = S_DONE;
          end else begin
            dsel_d  = (dsel_q == DIV_CX) ? DIV_CY : DIV_ASP;
            state_d = S_DGO;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.acc_clr  = 1'b1;
          state_d = S_ACCUM;
        end
      end
      default: state_d = S_ACCUM;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (cmd_o.out_load) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_ACCUM;
      cnt_q    <= '0;
      dsel_q   <= DIV_CX;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      dsel_q   <= dsel_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != S_ACCUM);
  assign out_valid_o = ovalid_q;

  a_final_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && final_pixel_i) |=> (state_q == S_MUL))
    else $error("final item did not start the moment products");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> ovalid_q)
    else $error("result load did not raise valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ovalid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  a_div_go_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_go |=> (state_q == S_DWAIT))
    else $error("divider started outside the division sequence");

  a_take_only_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pix_take |-> (state_q == S_ACCUM) && !cmd_o.mul_go)
    else $error("pixel taken outside accumulation");

endmodule

/* sv/blob_moment_features.sv */
// ----------------------------------------------------------------------------
// blob_moment_features
// Shape features of one object from a stream of its pixel coordinates:
// area, centroid, orientation, bounding box and aspect ratio.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o pix_x_i, pix_y_i, final_pixel_i
//   out      output     out_valid_o/out_stall_i area_o, centroid_x_o/y_o,
//                                               orientation_o, box_width_o,
//                                               box_height_o, aspect_ratio_o
//
// Pixels are accumulated at one item per cycle while in_stall_o is low. After
// the item marked final, in_stall_o stays high while the nine products run
// on the shared multiplier, the normalizer is loaded and shifts until both
// magnitudes are below 2^30, the CORDIC runs one rotation per cycle, the
// angle is rounded, three divisions run on the shared divider, which
// dominate, and the result register is loaded. That load waits as long as
// a previous result is still held under out_stall_i. Reset (rst_ni,
// asynchronous, active low) clears all accumulators and the controller; no
// result is pending afterwards.
// The result sits in an output register; while it waits under out_stall_i the
// block keeps taking pixels of the next object, and stalls only if the next
// object's result is ready before the previous one was taken.
//
// The orientation is 0.5*atan2(2*mu_xy, mu_yy - mu_xx) taken from moments
// scaled by the pixel count; the halving is folded into the Q20-to-Q2.13
// rounding together with the clamp to +-12868.
module blob_moment_features
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_W-1:0]      pix_x_i,
  input  logic [COORD_W-1:0]      pix_y_i,
  input  logic                    final_pixel_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CNT_W-1:0]        area_o,
  output logic [CENT_W-1:0]       centroid_x_o,
  output logic [CENT_W-1:0]       centroid_y_o,
  output logic signed [ORI_W-1:0] orientation_o,
  output logic [DIM_W-1:0]        box_width_o,
  output logic [DIM_W-1:0]        box_height_o,
  output logic [ASP_W-1:0]        aspect_ratio_o
);

  bmf_cmd_t    cmd;
  bmf_status_t status;

  // The controller sequences every step; the datapath only follows commands.
  bmf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .final_pixel_i(final_pixel_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  // Coordinates beyond the configured frame are clamped to its last
  // column or row inside the datapath.
  bmf_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .pix_x_i       (pix_x_i),
    .pix_y_i       (pix_y_i),
    .area_o        (area_o),
    .centroid_x_o  (centroid_x_o),
    .centroid_y_o  (centroid_y_o),
    .orientation_o (orientation_o),
    .box_width_o   (box_width_o),
    .box_height_o  (box_height_o),
    .aspect_ratio_o(aspect_ratio_o)
  );

endmodule
